FILE: rtl/core/zopd_pkg.sv
package zopd_pkg;

   localparam int DIST_W      = 16;
   localparam int STATUS_W    = 8;
   localparam int COUNT_W     = 3;
   localparam int COORD_W     = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int CMD_QUEUE_DEPTH = 2;

   localparam logic [COORD_W-1:0] REGION_ROW_BASE = 3'd3;
   localparam logic [COORD_W-1:0] REGION_COL_BASE = 3'd1;
   localparam logic [COORD_W-1:0] FRONT_ROW       = 3'd5;
   localparam logic [COORD_W-1:0] FRONT_COL_A     = 3'd3;
   localparam logic [COORD_W-1:0] FRONT_COL_B     = 3'd4;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DISTANCE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DISTANCE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNAL_THRESHOLD   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OBSTACLE_THRESHOLD = 2'd3;

   localparam logic [DIST_W-1:0]   MAX_DISTANCE_RESET       = 16'd4000;
   localparam logic [DIST_W-1:0]   MIN_DISTANCE_RESET       = 16'd10;
   localparam logic [STATUS_W-1:0] SIGNAL_THRESHOLD_RESET   = 8'd5;
   localparam logic [DIST_W-1:0]   OBSTACLE_THRESHOLD_RESET = 16'd200;
   localparam logic [DIST_W-1:0]   FRONT_NEAREST_RESET      = {DIST_W{1'b1}};

   typedef struct packed {
      logic               clear;
      logic               qualified;
      logic               in_region;
      logic               in_front;
      logic               last;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [DIST_W-1:0]  distance;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SCAN,
      BACK_DRAIN,
      BACK_EMIT
   } back_state_type;

endpackage

FILE: rtl/core/zopd_ram.sv
module zopd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 48
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/zopd_front.sv
module zopd_front
   import zopd_pkg::*;
#(
   parameter int REGION_ROWS = 2,
   parameter int REGION_COLS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_operation,
   input  logic [COORD_W-1:0]     req_zone_row,
   input  logic [COORD_W-1:0]     req_zone_col,
   input  logic [COUNT_W-1:0]     req_target_count,
   input  logic [DIST_W-1:0]      req_distance_mm,
   input  logic [STATUS_W-1:0]    req_target_status,
   input  logic                   req_last_zone,
   output logic [DIST_W-1:0]      obstacle_threshold,
   output cmd_type                cmd
);

   localparam logic [COORD_W:0] ROW_END = (COORD_W + 1)'(int'(REGION_ROW_BASE) + REGION_ROWS);
   localparam logic [COORD_W:0] COL_END = (COORD_W + 1)'(int'(REGION_COL_BASE) + REGION_COLS);

   logic [DIST_W-1:0]   max_dist_ff,  max_dist_in;
   logic [DIST_W-1:0]   min_dist_ff,  min_dist_in;
   logic [STATUS_W-1:0] signal_ff,    signal_in;
   logic [DIST_W-1:0]   obst_thr_ff,  obst_thr_in;

   logic is_clear;
   logic qualified;
   logic in_region;
   logic in_front;

   always_comb begin
      max_dist_in = max_dist_ff;
      min_dist_in = min_dist_ff;
      signal_in   = signal_ff;
      obst_thr_in = obst_thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_DISTANCE:       max_dist_in = csr_wr_data;
            CSR_MIN_DISTANCE:       min_dist_in = csr_wr_data;
            CSR_SIGNAL_THRESHOLD:   signal_in   = csr_wr_data[STATUS_W-1:0];
            CSR_OBSTACLE_THRESHOLD: obst_thr_in = csr_wr_data;
            default:                max_dist_in = max_dist_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= MAX_DISTANCE_RESET;
         min_dist_ff <= MIN_DISTANCE_RESET;
         signal_ff   <= SIGNAL_THRESHOLD_RESET;
         obst_thr_ff <= OBSTACLE_THRESHOLD_RESET;
      end else begin
         max_dist_ff <= max_dist_in;
         min_dist_ff <= min_dist_in;
         signal_ff   <= signal_in;
         obst_thr_ff <= obst_thr_in;
      end
   end

   // zone classification
   always_comb begin
      is_clear  = (req_operation == OP_CLEAR);
      qualified = (req_target_count != '0)
                  && (req_distance_mm <= max_dist_ff)
                  && (req_distance_mm >= min_dist_ff)
                  && (req_target_status >= signal_ff);
      in_region = (req_zone_row >= REGION_ROW_BASE) && ({1'b0, req_zone_row} < ROW_END)
                  && (req_zone_col >= REGION_COL_BASE) && ({1'b0, req_zone_col} < COL_END);
      in_front  = (req_zone_row == FRONT_ROW)
                  && ((req_zone_col == FRONT_COL_A) || (req_zone_col == FRONT_COL_B));

      cmd.clear     = is_clear;
      cmd.qualified = qualified;
      cmd.in_region = !is_clear && in_region;
      cmd.in_front  = !is_clear && in_front;
      cmd.last      = !is_clear && req_last_zone;
      cmd.row       = req_zone_row;
      cmd.col       = req_zone_col;
      cmd.distance  = req_distance_mm;
   end

   assign obstacle_threshold = obst_thr_ff;

endmodule

FILE: rtl/core/zopd_queue.sv
module zopd_queue
   import zopd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(CMD_QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(CMD_QUEUE_DEPTH);

   cmd_type         entry_ff [CMD_QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff,  count_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/zopd_back.sv
module zopd_back
   import zopd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 4,
   parameter int REGION_ROWS   = 2,
   parameter int REGION_COLS   = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   input  logic [DIST_W-1:0] obstacle_threshold,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_obstacle_detected,
   output logic              rsp_front_valid,
   output logic [DIST_W-1:0] rsp_front_distance
);

   localparam int ZONE_COUNT  = REGION_ROWS * REGION_COLS;
   localparam int ENTRY_COUNT = ZONE_COUNT * HISTORY_DEPTH;
   localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
   localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam logic [ZW-1:0] LAST_ZONE = ZW'(ZONE_COUNT - 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_DEPTH - 1);

   back_state_type state_ff, state_in;

   logic [SW-1:0]         slot_ff [ZONE_COUNT];
   logic [SW-1:0]         slot_in [ZONE_COUNT];
   logic [ZONE_COUNT-1:0] full_ff, full_in;

   logic              front_seen_ff, front_seen_in;
   logic [DIST_W-1:0] front_near_ff, front_near_in;

   logic [ZW-1:0] scan_zone_ff, scan_zone_in;
   logic [SW-1:0] scan_slot_ff, scan_slot_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;

   logic          pipe_valid_ff, pipe_valid_in;
   logic [ZW-1:0] pipe_zone_ff,  pipe_zone_in;
   logic          pipe_first_ff, pipe_first_in;
   logic          pipe_last_ff,  pipe_last_in;
   logic          zone_ok_ff,    zone_ok_in;
   logic          obstacle_ff,   obstacle_in;

   logic              rsp_valid_ff,  rsp_valid_in;
   logic              res_obst_ff,   res_obst_in;
   logic              res_fvalid_ff, res_fvalid_in;
   logic [DIST_W-1:0] res_fdist_ff,  res_fdist_in;

   logic              ram_wr_en;
   logic              ram_rd_en;
   logic              start_scan;
   logic              emit;
   logic              res_free;
   logic              scan_done;
   logic [ZW-1:0]     cmd_zone;
   logic [SW-1:0]     cmd_slot;
   logic [AW-1:0]     wr_addr_calc;
   logic [ZW-1:0]     full_idx;
   logic              full_sel;
   logic [DIST_W-1:0] ram_rd_data;
   logic              close;
   logic              zone_ok_cur;
   logic              zone_hit;

   // zone and ring slot of the queued request
   always_comb begin
      cmd_zone     = ZW'(cmd.row - REGION_ROW_BASE) * ZW'(REGION_COLS)
                     + ZW'(cmd.col - REGION_COL_BASE);
      cmd_slot     = slot_ff[cmd_zone];
      wr_addr_calc = AW'(cmd_zone) * AW'(HISTORY_DEPTH) + AW'(cmd_slot);
   end

   assign full_idx  = (state_ff == BACK_IDLE) ? cmd_zone : pipe_zone_ff;
   assign full_sel  = full_ff[full_idx];
   assign res_free  = !rsp_valid_ff || rsp_pop;
   assign scan_done = (scan_zone_ff == LAST_ZONE) && (scan_slot_ff == LAST_SLOT);

   zopd_ram #(
      .WIDTH (DIST_W),
      .DEPTH (ENTRY_COUNT)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr_calc),
      .wr_data (cmd.qualified ? cmd.distance : '0),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_addr_ff),
      .rd_data (ram_rd_data)
   );

   // history check of the entry read last cycle
   always_comb begin
      close       = (ram_rd_data != '0) && (ram_rd_data < obstacle_threshold);
      zone_ok_cur = close && (pipe_first_ff || zone_ok_ff);
      zone_hit    = pipe_valid_ff && pipe_last_ff && zone_ok_cur && full_sel;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty && cmd.last) begin
               state_in = BACK_SCAN;
            end
         end
         BACK_SCAN: begin
            if (scan_done) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: begin
            state_in = BACK_EMIT;
         end
         BACK_EMIT: begin
            if (res_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop    = 1'b0;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      start_scan = 1'b0;
      emit       = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            cmd_pop    = !cmd_empty;
            ram_wr_en  = !cmd_empty && cmd.in_region;
            start_scan = !cmd_empty && cmd.last;
         end
         BACK_SCAN: begin
            ram_rd_en = 1'b1;
         end
         BACK_EMIT: begin
            emit = res_free;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      slot_in       = slot_ff;
      full_in       = full_ff;
      front_seen_in = front_seen_ff;
      front_near_in = front_near_ff;
      scan_zone_in  = scan_zone_ff;
      scan_slot_in  = scan_slot_ff;
      scan_addr_in  = scan_addr_ff;
      pipe_valid_in = ram_rd_en;
      pipe_zone_in  = scan_zone_ff;
      pipe_first_in = (scan_slot_ff == '0);
      pipe_last_in  = (scan_slot_ff == LAST_SLOT);
      zone_ok_in    = zone_ok_ff;
      obstacle_in   = obstacle_ff;
      rsp_valid_in  = rsp_valid_ff;
      res_obst_in   = res_obst_ff;
      res_fvalid_in = res_fvalid_ff;
      res_fdist_in  = res_fdist_ff;

      if (cmd_pop) begin
         if (cmd.clear) begin
            slot_in = '{default: '0};
            full_in = '0;
         end else if (cmd.in_region) begin
            slot_in[cmd_zone] = (cmd_slot == LAST_SLOT) ? '0 : SW'(cmd_slot + 1'b1);
            if (cmd_slot == LAST_SLOT) begin
               full_in[cmd_zone] = 1'b1;
            end
         end
         if (cmd.in_front && cmd.qualified
             && (!front_seen_ff || (cmd.distance < front_near_ff))) begin
            front_seen_in = 1'b1;
            front_near_in = cmd.distance;
         end
      end

      if (start_scan) begin
         scan_zone_in = '0;
         scan_slot_in = '0;
         scan_addr_in = '0;
         obstacle_in  = 1'b0;
      end

      if (ram_rd_en) begin
         scan_addr_in = AW'(scan_addr_ff + 1'b1);
         if (scan_slot_ff == LAST_SLOT) begin
            scan_slot_in = '0;
            scan_zone_in = ZW'(scan_zone_ff + 1'b1);
         end else begin
            scan_slot_in = SW'(scan_slot_ff + 1'b1);
         end
      end

      if (pipe_valid_ff) begin
         zone_ok_in = zone_ok_cur;
      end
      if (zone_hit) begin
         obstacle_in = 1'b1;
      end

      if (emit) begin
         rsp_valid_in  = 1'b1;
         res_obst_in   = obstacle_ff;
         res_fvalid_in = front_seen_ff;
         res_fdist_in  = front_seen_ff ? front_near_ff : '0;
         front_seen_in = 1'b0;
         front_near_in = FRONT_NEAREST_RESET;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         slot_ff       <= '{default: '0};
         full_ff       <= '0;
         front_seen_ff <= 1'b0;
         front_near_ff <= FRONT_NEAREST_RESET;
         pipe_valid_ff <= 1'b0;
         obstacle_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         full_ff       <= full_in;
         front_seen_ff <= front_seen_in;
         front_near_ff <= front_near_in;
         pipe_valid_ff <= pipe_valid_in;
         obstacle_ff   <= obstacle_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_zone_ff  <= scan_zone_in;
      scan_slot_ff  <= scan_slot_in;
      scan_addr_ff  <= scan_addr_in;
      pipe_zone_ff  <= pipe_zone_in;
      pipe_first_ff <= pipe_first_in;
      pipe_last_ff  <= pipe_last_in;
      zone_ok_ff    <= zone_ok_in;
      res_obst_ff   <= res_obst_in;
      res_fvalid_ff <= res_fvalid_in;
      res_fdist_ff  <= res_fdist_in;
   end

   assign rsp_empty             = !rsp_valid_ff;
   assign rsp_obstacle_detected = res_obst_ff;
   assign rsp_front_valid       = res_fvalid_ff;
   assign rsp_front_distance    = res_fdist_ff;

endmodule

FILE: rtl/core/zone_obstacle_persistence_detector_top.sv
// zone samples and clear requests: one per cycle while the back end is idle, executed from the request queue
// last zone of a frame: history scan of all REGION_ROWS*REGION_COLS*HISTORY_DEPTH entries,
//    one history memory read per cycle, result registered after the scan via DRAIN and EMIT
// no request executes during the scan, the drain, or while the new result waits for the previous one to be read;
//    the 2-entry request queue keeps accepting until full
module zone_obstacle_persistence_detector_top
   import zopd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 4,
   parameter int REGION_ROWS   = 2,
   parameter int REGION_COLS   = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_operation,
   input  logic [COORD_W-1:0]     req_zone_row,
   input  logic [COORD_W-1:0]     req_zone_col,
   input  logic [COUNT_W-1:0]     req_target_count,
   input  logic [DIST_W-1:0]      req_distance_mm,
   input  logic [STATUS_W-1:0]    req_target_status,
   input  logic                   req_last_zone,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_obstacle_detected,
   output logic                   rsp_front_valid,
   output logic [DIST_W-1:0]      rsp_front_distance
);

   // synchronous active-high reset: thresholds to defaults, histories empty, no result pending

   cmd_type           front_cmd;
   cmd_type           back_cmd;
   logic              cmd_empty;
   logic              cmd_pop;
   logic [DIST_W-1:0] obstacle_threshold;

   zopd_front #(
      .REGION_ROWS (REGION_ROWS),
      .REGION_COLS (REGION_COLS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_operation      (req_operation),
      .req_zone_row       (req_zone_row),
      .req_zone_col       (req_zone_col),
      .req_target_count   (req_target_count),
      .req_distance_mm    (req_distance_mm),
      .req_target_status  (req_target_status),
      .req_last_zone      (req_last_zone),
      .obstacle_threshold (obstacle_threshold),
      .cmd                (front_cmd)
   );

   zopd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty)
   );

   zopd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .REGION_ROWS   (REGION_ROWS),
      .REGION_COLS   (REGION_COLS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cmd_empty             (cmd_empty),
      .cmd                   (back_cmd),
      .cmd_pop               (cmd_pop),
      .obstacle_threshold    (obstacle_threshold),
      .rsp_empty             (empty),
      .rsp_pop               (pop),
      .rsp_obstacle_detected (rsp_obstacle_detected),
      .rsp_front_valid       (rsp_front_valid),
      .rsp_front_distance    (rsp_front_distance)
   );

endmodule

FILE: test/zone_obstacle_persistence_detector_top_test.sv
`timescale 1ns / 1ps

module zone_obstacle_persistence_detector_top_test
   import zopd_pkg::*;
();

   localparam int HISTORY_DEPTH   = 4;
   localparam int REGION_ROWS     = 2;
   localparam int REGION_COLS     = 6;
   localparam int REGION_ZONES    = REGION_ROWS * REGION_COLS;
   localparam int RANDOM_REQUESTS = 1200;
   localparam int PHASE_REQUESTS  = 100;
   localparam int SETTLE_CYCLES   = 80;
   localparam int LONG_HOLD       = 3000;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIRECTED_ROWS   = 25;

   typedef struct packed {
      logic                op;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [COUNT_W-1:0]  count;
      logic [DIST_W-1:0]   range_mm;
      logic [STATUS_W-1:0] status;
      logic                last;
   } zone_request_type;

   typedef struct packed {
      logic              obstacle;
      logic              front_valid;
      logic [DIST_W-1:0] near_mm;
   } verdict_type;

   typedef enum bit {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] csr_sel;
      logic                   op;
      logic [COORD_W-1:0]     row;
      logic [COORD_W-1:0]     col;
      logic [COUNT_W-1:0]     count;
      logic [DIST_W-1:0]      range_mm;
      logic [STATUS_W-1:0]    status;
      logic                   last;
      bit                     typed;
      logic                   obstacle;
      logic                   front_valid;
      logic [DIST_W-1:0]      near_mm;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   logic                   push;
   logic                   full;
   logic                   req_operation;
   logic [COORD_W-1:0]     req_zone_row;
   logic [COORD_W-1:0]     req_zone_col;
   logic [COUNT_W-1:0]     req_target_count;
   logic [DIST_W-1:0]      req_distance_mm;
   logic [STATUS_W-1:0]    req_target_status;
   logic                   req_last_zone;
   logic                   empty;
   logic                   pop;
   logic                   rsp_obstacle_detected;
   logic                   rsp_front_valid;
   logic [DIST_W-1:0]      rsp_front_distance;

   logic [DIST_W-1:0]   cfg_max;
   logic [DIST_W-1:0]   cfg_min;
   logic [STATUS_W-1:0] cfg_signal;
   logic [DIST_W-1:0]   cfg_obstacle;

   logic [DIST_W-1:0] zone_readings [REGION_ZONES][HISTORY_DEPTH];
   int                zone_slot [REGION_ZONES];
   int                zone_fill [REGION_ZONES];
   logic [DIST_W-1:0] front_nearest_mm;
   bit                front_seen_now;

   verdict_type pending_verdicts [$];
   bit          close_zone [REGION_ZONES];
   int          requests_sent;
   int          mismatches;
   bit          quiet_phase;
   bit          long_hold_due;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd0, 3'd0, 3'd0, 16'd0, 8'd0, 1'b1,
        1'b1, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd5, 3'd3, 3'd4, 16'd1000, 8'd255, 1'b1,
        1'b1, 1'b0, 1'b1, 16'd1000},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd5, 3'd4, 3'd1, 16'd4000, 8'd5, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd5, 3'd3, 3'd7, 16'd10, 8'd5, 1'b1,
        1'b1, 1'b0, 1'b1, 16'd10},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd5, 3'd4, 3'd1, 16'd4001, 8'd255, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd5, 3'd3, 3'd1, 16'd9, 8'd4, 1'b1,
        1'b1, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd3, 3'd1, 3'd1, 16'd199, 8'd5, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd3, 3'd1, 3'd1, 16'd199, 8'd5, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd3, 3'd1, 3'd1, 16'd199, 8'd5, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd3, 3'd1, 3'd1, 16'd199, 8'd5, 1'b1,
        1'b1, 1'b1, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_CLEAR, 3'd3, 3'd1, 3'd0, 16'd0, 8'd0, 1'b1,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd7, 3'd7, 3'd7, 16'd65535, 8'd255, 1'b1,
        1'b1, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd4, 3'd6, 3'd2, 16'd200, 8'd100, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd4, 3'd6, 3'd2, 16'd200, 8'd100, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd4, 3'd6, 3'd2, 16'd200, 8'd100, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd4, 3'd6, 3'd2, 16'd200, 8'd100, 1'b1,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_CSR, CSR_MIN_DISTANCE, OP_SAMPLE, 3'd0, 3'd0, 3'd0, 16'd0, 8'd0, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd4, 3'd2, 3'd1, 16'd0, 8'd5, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd4, 3'd2, 3'd1, 16'd0, 8'd5, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd4, 3'd2, 3'd1, 16'd0, 8'd5, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd4, 3'd2, 3'd1, 16'd0, 8'd5, 1'b1,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_CSR, CSR_OBSTACLE_THRESHOLD, OP_SAMPLE, 3'd0, 3'd0, 3'd0, 16'd65535, 8'd0, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_CSR, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd0, 3'd0, 3'd0, 16'd65535, 8'd0, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_CSR, CSR_SIGNAL_THRESHOLD, OP_SAMPLE, 3'd0, 3'd0, 3'd0, 16'd0, 8'd0, 1'b0,
        1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_REQUEST, CSR_MAX_DISTANCE, OP_SAMPLE, 3'd2, 3'd0, 3'd0, 16'd65535, 8'd0, 1'b1,
        1'b0, 1'b0, 1'b0, 16'd0}
   };

   zone_obstacle_persistence_detector_top #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .REGION_ROWS  (REGION_ROWS),
      .REGION_COLS  (REGION_COLS)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .push                 (push),
      .full                 (full),
      .req_operation        (req_operation),
      .req_zone_row         (req_zone_row),
      .req_zone_col         (req_zone_col),
      .req_target_count     (req_target_count),
      .req_distance_mm      (req_distance_mm),
      .req_target_status    (req_target_status),
      .req_last_zone        (req_last_zone),
      .empty                (empty),
      .pop                  (pop),
      .rsp_obstacle_detected(rsp_obstacle_detected),
      .rsp_front_valid      (rsp_front_valid),
      .rsp_front_distance   (rsp_front_distance)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("Verification failed");
      $finish;
   end

   task automatic forget_histories();
      foreach (zone_readings[z, i]) zone_readings[z][i] = '0;
      foreach (zone_slot[z]) begin
         zone_slot[z] = 0;
         zone_fill[z] = 0;
      end
   endtask

   task automatic predict_request(input zone_request_type r, output bit produced,
                                  output verdict_type v);
      bit qualified;
      bit close;
      int zi;
      produced = 1'b0;
      v = '0;
      if (r.op == OP_CLEAR) begin
         forget_histories();
         return;
      end
      qualified = r.count != 0 && r.range_mm <= cfg_max && r.range_mm >= cfg_min
                  && r.status >= cfg_signal;
      if (r.row >= REGION_ROW_BASE && r.row < REGION_ROW_BASE + REGION_ROWS
          && r.col >= REGION_COL_BASE && r.col < REGION_COL_BASE + REGION_COLS) begin
         zi = (r.row - REGION_ROW_BASE) * REGION_COLS + (r.col - REGION_COL_BASE);
         zone_readings[zi][zone_slot[zi]] = qualified ? r.range_mm : '0;
         zone_slot[zi] = (zone_slot[zi] + 1) % HISTORY_DEPTH;
         if (zone_fill[zi] < HISTORY_DEPTH) zone_fill[zi]++;
      end
      if (r.row == FRONT_ROW && (r.col == FRONT_COL_A || r.col == FRONT_COL_B) && qualified
          && (!front_seen_now || r.range_mm < front_nearest_mm)) begin
         front_nearest_mm = r.range_mm;
         front_seen_now = 1'b1;
      end
      if (!r.last) return;
      produced = 1'b1;
      for (int z = 0; z < REGION_ZONES; z++) begin
         close = zone_fill[z] >= HISTORY_DEPTH;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (zone_readings[z][i] == 0 || zone_readings[z][i] >= cfg_obstacle) close = 1'b0;
         end
         if (close) v.obstacle = 1'b1;
      end
      v.front_valid = front_seen_now;
      v.near_mm = front_seen_now ? front_nearest_mm : '0;
      front_nearest_mm = FRONT_NEAREST_RESET;
      front_seen_now = 1'b0;
   endtask

   task automatic check_verdict();
      verdict_type want;
      if (pending_verdicts.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: obstacle %0b front_valid %0b front distance %0d",
                     rsp_obstacle_detected, rsp_front_valid, rsp_front_distance);
         return;
      end
      want = pending_verdicts.pop_front();
      if (rsp_obstacle_detected !== want.obstacle || rsp_front_valid !== want.front_valid
          || rsp_front_distance !== want.near_mm) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("result mismatch: expected %0b %0b %0d, got %0b %0b %0d",
                     want.obstacle, want.front_valid, want.near_mm,
                     rsp_obstacle_detected, rsp_front_valid, rsp_front_distance);
      end
   endtask

   initial begin : result_side
      int hold_left;
      hold_left = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (pop && !empty) check_verdict();
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= quiet_phase || $urandom_range(99) >= 8;
         end
      end
   end

   task automatic offer_request(input zone_request_type r, input bit typed = 1'b0,
                                input verdict_type typed_verdict = '0);
      bit produced;
      verdict_type v;
      while (!quiet_phase && $urandom_range(99) < 8) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_operation <= r.op;
      req_zone_row <= r.row;
      req_zone_col <= r.col;
      req_target_count <= r.count;
      req_distance_mm <= r.range_mm;
      req_target_status <= r.status;
      req_last_zone <= r.last;
      do @(posedge clock); while (full);
      predict_request(r, produced, v);
      if (produced) pending_verdicts.push_back(typed ? typed_verdict : v);
      requests_sent++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] sel,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wr_data <= data;
      @(posedge clock);
      case (sel)
         CSR_MAX_DISTANCE:       cfg_max = data;
         CSR_MIN_DISTANCE:       cfg_min = data;
         CSR_SIGNAL_THRESHOLD:   cfg_signal = data[STATUS_W-1:0];
         CSR_OBSTACLE_THRESHOLD: cfg_obstacle = data;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [DIST_W-1:0] pick_distance();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return cfg_min;
         3:       return cfg_max;
         4:       return cfg_obstacle;
         5:       return cfg_obstacle - 1'b1;
         default: return DIST_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic zone_request_type clear_request();
      zone_request_type r;
      r = zone_request_type'({$urandom, $urandom});
      r.op = OP_CLEAR;
      return r;
   endfunction

   function automatic zone_request_type make_sample(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col,
                                                    input bit near);
      zone_request_type r;
      int lo;
      int hi;
      r.op = OP_SAMPLE;
      r.row = row;
      r.col = col;
      r.last = 1'b0;
      lo = (cfg_min == 0) ? 1 : int'(cfg_min);
      hi = int'(cfg_obstacle) - 1;
      if (hi > int'(cfg_max)) hi = int'(cfg_max);
      if (near && lo <= hi && $urandom_range(9) != 0) begin
         r.count = COUNT_W'($urandom_range(4, 1));
         r.range_mm = DIST_W'($urandom_range(hi, lo));
         r.status = STATUS_W'($urandom_range(255, cfg_signal));
      end else if ($urandom_range(1) == 1) begin
         r.count = COUNT_W'($urandom_range(4, 1));
         r.range_mm = (cfg_min <= cfg_max) ? DIST_W'($urandom_range(cfg_max, cfg_min))
                                           : pick_distance();
         r.status = STATUS_W'($urandom_range(255, cfg_signal));
      end else begin
         r.count = COUNT_W'($urandom_range(7));
         r.range_mm = pick_distance();
         r.status = STATUS_W'($urandom_range(255));
      end
      return r;
   endfunction

   // a full scan of the region and both front zones, shuffled, plus a little noise
   task automatic send_frame(input bit broken);
      logic [6:0] spots [$];
      logic [6:0] swap;
      int j;
      zone_request_type r;
      for (int z = 0; z < REGION_ZONES; z++)
         spots.push_back({close_zone[z], COORD_W'(REGION_ROW_BASE + z / REGION_COLS),
                          COORD_W'(REGION_COL_BASE + z % REGION_COLS)});
      spots.push_back({1'($urandom_range(1)), FRONT_ROW, FRONT_COL_A});
      spots.push_back({1'($urandom_range(1)), FRONT_ROW, FRONT_COL_B});
      repeat ($urandom_range(2)) spots.push_back({1'b0, 6'($urandom_range(63))});
      for (int i = spots.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         swap = spots[i];
         spots[i] = spots[j];
         spots[j] = swap;
      end
      foreach (spots[i]) begin
         if ($urandom_range(99) < 4) offer_request(clear_request());
         r = make_sample(spots[i][5:3], spots[i][2:0], spots[i][6]);
         r.last = (i == spots.size() - 1) && !broken;
         offer_request(r);
      end
   endtask

   task automatic send_loose_items(input int count, input int last_pct);
      zone_request_type r;
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            r = clear_request();
         end else if (pick < 55) begin
            pick = $urandom_range(REGION_ZONES - 1);
            r = make_sample(COORD_W'(REGION_ROW_BASE + pick / REGION_COLS),
                            COORD_W'(REGION_COL_BASE + pick % REGION_COLS), close_zone[pick]);
         end else if (pick < 75) begin
            r = make_sample(FRONT_ROW, $urandom_range(1) ? FRONT_COL_A : FRONT_COL_B,
                            1'($urandom_range(1)));
         end else begin
            r = make_sample(COORD_W'($urandom_range(7)), COORD_W'($urandom_range(7)),
                            1'($urandom_range(1)));
         end
         r.last = $urandom_range(99) < last_pct;
         offer_request(r);
      end
   endtask

   initial begin : request_side
      zone_request_type r;
      verdict_type typed_verdict;
      int phase;
      int phase_start;
      int random_start;
      logic [DIST_W-1:0] next_max;
      logic [DIST_W-1:0] next_min;
      logic [CSR_DATA_W-1:0] next_signal;
      logic [DIST_W-1:0] next_obstacle;

      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_MAX_DISTANCE;
      csr_wr_data <= '0;
      push <= 1'b0;
      req_operation <= OP_SAMPLE;
      req_zone_row <= '0;
      req_zone_col <= '0;
      req_target_count <= '0;
      req_distance_mm <= '0;
      req_target_status <= '0;
      req_last_zone <= 1'b0;
      cfg_max = MAX_DISTANCE_RESET;
      cfg_min = MIN_DISTANCE_RESET;
      cfg_signal = SIGNAL_THRESHOLD_RESET;
      cfg_obstacle = OBSTACLE_THRESHOLD_RESET;
      forget_histories();
      front_nearest_mm = FRONT_NEAREST_RESET;
      front_seen_now = 1'b0;
      requests_sent = 0;
      mismatches = 0;
      quiet_phase = 1'b0;
      long_hold_due = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_register(directed_rows[i].csr_sel, directed_rows[i].range_mm);
            csr_wr_en <= 1'b0;
         end else begin
            r.op = directed_rows[i].op;
            r.row = directed_rows[i].row;
            r.col = directed_rows[i].col;
            r.count = directed_rows[i].count;
            r.range_mm = directed_rows[i].range_mm;
            r.status = directed_rows[i].status;
            r.last = directed_rows[i].last;
            typed_verdict.obstacle = directed_rows[i].obstacle;
            typed_verdict.front_valid = directed_rows[i].front_valid;
            typed_verdict.near_mm = directed_rows[i].near_mm;
            offer_request(r, directed_rows[i].typed, typed_verdict);
         end
      end
      wait_idle();

      phase = 0;
      random_start = requests_sent;
      while (requests_sent - random_start < RANDOM_REQUESTS) begin
         case (phase % 5)
            1: begin
               next_max = '1;
               next_min = '0;
               next_signal = '0;
               next_obstacle = '1;
            end
            2: begin
               next_max = '0;
               next_min = '1;
               next_signal = '1;
               next_obstacle = '0;
            end
            3: begin
               next_max = MAX_DISTANCE_RESET;
               next_min = MIN_DISTANCE_RESET;
               next_signal = CSR_DATA_W'(SIGNAL_THRESHOLD_RESET);
               next_obstacle = OBSTACLE_THRESHOLD_RESET;
            end
            4: begin
               next_max = DIST_W'($urandom_range(65535));
               next_min = DIST_W'($urandom_range(65535));
               next_signal = CSR_DATA_W'($urandom_range(65535));
               next_obstacle = DIST_W'($urandom_range(65535));
            end
            default: begin
               next_max = DIST_W'($urandom_range(65535, 500));
               next_min = DIST_W'($urandom_range(60));
               next_signal = CSR_DATA_W'($urandom_range(40));
               next_obstacle = DIST_W'($urandom_range(3000, 1));
            end
         endcase
         write_register(CSR_MAX_DISTANCE, next_max);
         write_register(CSR_MIN_DISTANCE, next_min);
         write_register(CSR_SIGNAL_THRESHOLD, next_signal);
         write_register(CSR_OBSTACLE_THRESHOLD, next_obstacle);
         csr_wr_en <= 1'b0;
         quiet_phase = phase == 3;
         foreach (close_zone[z]) close_zone[z] = $urandom_range(99) < 35;
         phase_start = requests_sent;
         if (phase == 5) begin
            // result side holds off while requests keep coming, so the block backs up
            long_hold_due = 1'b1;
            send_loose_items(PHASE_REQUESTS, 60);
         end
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            if ($urandom_range(9) == 0) send_loose_items(int'($urandom_range(6, 1)), 10);
            else send_frame($urandom_range(19) == 0);
         end
         wait_idle();
         phase++;
      end

      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
